@@ rtl/core/three_level_exclusive_lru_cache_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the three-level LRU cache
// Implication checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_EXCLUSIVE_LRU_CACHE_ASSERT_SVH
`define THREE_LEVEL_EXCLUSIVE_LRU_CACHE_ASSERT_SVH

// same-cycle implication
`define TLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tlcache_pkg.sv @@
// ----------------------------------------------------------------------------
// tlcache_pkg
// Shared widths, codes and control bundles of the three-level LRU cache.
// ----------------------------------------------------------------------------
package tlcache_pkg;

  localparam int unsigned LAT_W      = 10;
  localparam int unsigned ACC_W      = 12;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned MISS_W     = 32;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned EXTRA_W    = 16;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned IN_W       = 48;
  localparam int unsigned OUT_W      = 96;

  localparam logic [LAT_W-1:0] L1_LAT_RST  = 10'd4;
  localparam logic [LAT_W-1:0] L2_LAT_RST  = 10'd12;
  localparam logic [LAT_W-1:0] L3_LAT_RST  = 10'd40;
  localparam logic [LAT_W-1:0] RAM_LAT_RST = 10'd200;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_L1_LAT  = 2'd0,
    REG_L2_LAT  = 2'd1,
    REG_L3_LAT  = 2'd2,
    REG_RAM_LAT = 2'd3
  } cfg_reg_t;

  typedef enum logic [LEVEL_W-1:0] {
    LVL_L1  = 2'd0,
    LVL_L2  = 2'd1,
    LVL_L3  = 2'd2,
    LVL_RAM = 2'd3
  } hit_level_t;

  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic ins;
    logic block;
  } lvl_ctrl_t;

  typedef struct packed {
    logic hit;
    logic evict;
  } lvl_stat_t;

endpackage

@@ rtl/core/tlcache_cell.sv @@
// ----------------------------------------------------------------------------
// tlcache_cell
// One LRU slot: holds a block id and occupancy, compares against the key and
// takes its neighbor's contents when told to shift.
// ----------------------------------------------------------------------------
module tlcache_cell #(
  parameter int unsigned ID_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmp_en,
  input  logic               shift_en,
  input  logic [ID_BITS-1:0] key,
  input  logic [ID_BITS-1:0] prev_data,
  input  logic               prev_valid,
  output logic [ID_BITS-1:0] data,
  output logic               valid,
  output logic               match
);

  logic [ID_BITS-1:0] data_r;
  logic               valid_r;
  logic               match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (cmp_en) begin
        match_r <= valid_r & (data_r == key);
      end
      if (shift_en) begin
        valid_r <= prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= prev_data;
    end
  end

  assign data  = data_r;
  assign valid = valid_r;
  assign match = match_r;

endmodule

@@ rtl/core/tlcache_level.sv @@
`include "three_level_exclusive_lru_cache_assert.svh"
// ----------------------------------------------------------------------------
// tlcache_level
// One cache level as a row of LRU cells, front at cell 0. A hit moves the
// cells ahead of it back by one; an insert without a hit shifts the whole row
// and pushes out the last entry.
// ----------------------------------------------------------------------------
module tlcache_level #(
  parameter int unsigned DEPTH   = 32,
  parameter int unsigned ID_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tlcache_pkg::lvl_ctrl_t ctrl,
  input  logic [ID_BITS-1:0]     key,
  input  logic [ID_BITS-1:0]     front,
  output tlcache_pkg::lvl_stat_t stat,
  output logic [ID_BITS-1:0]     victim
);
  import tlcache_pkg::*;

  logic [ID_BITS-1:0] data_a [DEPTH];
  logic [DEPTH-1:0]   valid_v;
  logic [DEPTH-1:0]   match_v;
  logic [DEPTH-1:0]   hit_v;
  logic [DEPTH-1:0]   sel_v;
  logic [DEPTH-1:0]   shift_v;
  logic               hit;

  assign hit_v   = match_v & {DEPTH{~ctrl.block}};
  assign hit     = |hit_v;
  assign sel_v   = hit_v | (hit_v - DEPTH'(1));
  assign shift_v = {DEPTH{ctrl.upd_en & ctrl.ins}} & (sel_v | {DEPTH{~hit}});

  assign stat.hit   = hit;
  assign stat.evict = ctrl.ins & ~hit & valid_v[DEPTH-1];
  assign victim     = data_a[DEPTH-1];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0] prev_data;
    logic               prev_valid;

    if (i == 0) begin : g_head
      assign prev_data  = front;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_data  = data_a[i-1];
      assign prev_valid = valid_v[i-1];
    end

    tlcache_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmp_en     (ctrl.cmp_en),
      .shift_en   (shift_v[i]),
      .key        (key),
      .prev_data  (prev_data),
      .prev_valid (prev_valid),
      .data       (data_a[i]),
      .valid      (valid_v[i]),
      .match      (match_v[i])
    );
  end

  `TLC_ASSERT_IMP(a_single_match, 1'b1, $onehot0(match_v), "level holds a block id twice")
  `TLC_ASSERT_IMP(a_fill_contig, 1'b1, ((valid_v >> 1) & ~valid_v) == '0, "level fill has a gap")

endmodule

@@ rtl/core/three_level_exclusive_lru_cache.sv @@
`include "three_level_exclusive_lru_cache_assert.svh"
// ----------------------------------------------------------------------------
// three_level_exclusive_lru_cache
// Exclusive L1/L2/L3 LRU cache model with latency and RAM-miss accounting.
//
//   channel | dir | handshake                      | payload
//   in_     | in  | in_tvalid / in_tready          | in_tdata: block_id, extra_cycles
//   out_    | out | out_tvalid / out_tready        | out_tdata: hit_level .. ram_misses
//   cfg_    | in  | cfg_valid / cfg_ready          | cfg_addr, cfg_data
//
// On accept, every cell of all three levels compares the key and registers its
// match; in S_UPD the cell rows shift and the result loads. Reset clears
// occupancy, match, state, output-valid and counters and reloads the latency
// registers; cell data is never cleared. The update waits while the output
// register still holds an unread result; a new request is taken once the update has gone through.
// ----------------------------------------------------------------------------
module three_level_exclusive_lru_cache #(
  parameter int unsigned L1_DEPTH      = 32,
  parameter int unsigned L2_DEPTH      = 128,
  parameter int unsigned L3_DEPTH      = 512,
  parameter int unsigned BLOCK_ID_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tlcache_pkg::IN_W-1:0]       in_tdata,   // block_id, extra_cycles
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tlcache_pkg::OUT_W-1:0]      out_tdata,  // hit_level, access_latency,
                                                         // total_latency, ram_misses
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlcache_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tlcache_pkg::LAT_W-1:0]      cfg_data
);
  import tlcache_pkg::*;

  localparam int unsigned OUT_PAD = OUT_W - LEVEL_W - ACC_W - SUM_W - MISS_W;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  state_t                 state_r;
  logic [BLOCK_ID_BITS-1:0] key_r;
  logic [EXTRA_W-1:0]     extra_r;
  logic [LAT_W-1:0]       l1_lat_r;
  logic [LAT_W-1:0]       l2_lat_r;
  logic [LAT_W-1:0]       l3_lat_r;
  logic [LAT_W-1:0]       ram_lat_r;
  logic                   out_valid_r;
  hit_level_t             out_level_r;
  logic [ACC_W-1:0]       out_acc_r;
  logic [SUM_W-1:0]       sum_r;
  logic [MISS_W-1:0]      miss_r;

  logic                     accept;
  logic                     commit;
  logic [BLOCK_ID_BITS-1:0] in_key;
  lvl_ctrl_t                ctl1, ctl2, ctl3;
  lvl_stat_t                st1, st2, st3;
  logic [BLOCK_ID_BITS-1:0] vic1, vic2, vic3;
  hit_level_t               level;
  logic [ACC_W-1:0]         lat_l1, lat_l2, lat_l3, lat_ram;
  logic [ACC_W-1:0]         acc_nxt;
  logic [SUM_W-1:0]         sum_nxt;
  logic [MISS_W-1:0]        miss_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign commit    = (state_r == S_UPD) & (~out_valid_r | out_tready);
  assign in_key    = BLOCK_ID_BITS'(in_tdata[ID_W-1:0]);
  assign cfg_ready = 1'b1;

  assign ctl1 = '{cmp_en: accept, upd_en: commit, ins: 1'b1, block: 1'b0};
  assign ctl2 = '{cmp_en: accept, upd_en: commit, ins: st1.evict, block: st1.hit};
  assign ctl3 = '{cmp_en: accept, upd_en: commit, ins: st2.evict,
                  block: st1.hit | st2.hit};

  tlcache_level #(.DEPTH(L1_DEPTH), .ID_BITS(BLOCK_ID_BITS)) u_l1 (
    .clk (clk), .rst_n (rst_n), .ctrl (ctl1), .key (in_key), .front (key_r),
    .stat (st1), .victim (vic1)
  );

  tlcache_level #(.DEPTH(L2_DEPTH), .ID_BITS(BLOCK_ID_BITS)) u_l2 (
    .clk (clk), .rst_n (rst_n), .ctrl (ctl2), .key (in_key), .front (vic1),
    .stat (st2), .victim (vic2)
  );

  tlcache_level #(.DEPTH(L3_DEPTH), .ID_BITS(BLOCK_ID_BITS)) u_l3 (
    .clk (clk), .rst_n (rst_n), .ctrl (ctl3), .key (in_key), .front (vic2),
    .stat (st3), .victim (vic3)
  );

  always_comb begin
    if (st1.hit) begin
      level = LVL_L1;
    end else if (st2.hit) begin
      level = LVL_L2;
    end else if (st3.hit) begin
      level = LVL_L3;
    end else begin
      level = LVL_RAM;
    end
  end

  assign lat_l1  = ACC_W'(l1_lat_r);
  assign lat_l2  = lat_l1 + ACC_W'(l2_lat_r);
  assign lat_l3  = lat_l2 + ACC_W'(l3_lat_r);
  assign lat_ram = lat_l3 + ACC_W'(ram_lat_r);

  always_comb begin
    unique case (level)
      LVL_L1:  acc_nxt = lat_l1;
      LVL_L2:  acc_nxt = lat_l2;
      LVL_L3:  acc_nxt = lat_l3;
      LVL_RAM: acc_nxt = lat_ram;
      default: acc_nxt = lat_ram;
    endcase
  end

  assign sum_nxt  = sum_r + SUM_W'(extra_r) + SUM_W'(acc_nxt);
  assign miss_nxt = (level == LVL_RAM) ? miss_r + MISS_W'(1) : miss_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r   <= in_key;
      extra_r <= in_tdata[ID_W +: EXTRA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_lat_r  <= L1_LAT_RST;
      l2_lat_r  <= L2_LAT_RST;
      l3_lat_r  <= L3_LAT_RST;
      ram_lat_r <= RAM_LAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_L1_LAT:  l1_lat_r  <= cfg_data;
        REG_L2_LAT:  l2_lat_r  <= cfg_data;
        REG_L3_LAT:  l3_lat_r  <= cfg_data;
        REG_RAM_LAT: ram_lat_r <= cfg_data;
        default:     l1_lat_r  <= l1_lat_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      miss_r      <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (commit) begin
            out_valid_r <= 1'b1;
            out_level_r <= level;
            out_acc_r   <= acc_nxt;
            sum_r       <= sum_nxt;
            miss_r      <= miss_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, miss_r, sum_r, out_acc_r, out_level_r};

  `TLC_ASSERT_IMP(a_one_level_hit, state_r == S_UPD, $onehot0({st1.hit, st2.hit, st3.hit}), "block found in more than one level")
  `TLC_ASSERT_IMP(a_l2_hit_l1_full, state_r == S_UPD && st2.hit, ctl2.ins, "L2 hit while L1 not full")
  `TLC_ASSERT_NXT(a_miss_count, commit && level == LVL_RAM, miss_r == $past(miss_r) + MISS_W'(1), "RAM miss not counted")

endmodule
